// ===== src/acr_pkg.sv =====
package acr_pkg;

  // Cache geometry
  localparam int unsigned HOST_BITS_DEF = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MY_IP   = 2'd0,
    CFG_MY_MAC  = 2'd1,
    CFG_MASK    = 2'd2,
    CFG_GATEWAY = 2'd3
  } cfg_idx_e;

  // Register reset values: 192.168.1.30, MAC 0, 255.255.255.0, 192.168.1.1
  localparam logic [31:0] MY_IP_RST   = 32'hC0A8_011E;
  localparam logic [47:0] MY_MAC_RST  = 48'h0;
  localparam logic [31:0] MASK_RST    = 32'hFFFF_FF00;
  localparam logic [31:0] GATEWAY_RST = 32'hC0A8_0101;

  // ARP operation codes
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  // Item kinds
  localparam logic ACT_ARP     = 1'b0;
  localparam logic ACT_RESOLVE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] arp_opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } acr_in_t;

  typedef struct packed {
    logic        reply_valid;
    logic [47:0] reply_dest_mac;
    logic [31:0] reply_target_ip;
    logic        resolve_hit;
    logic [47:0] resolved_mac;
    logic        request_valid;
    logic [31:0] next_hop_ip;
  } acr_out_t;

endpackage

// ===== src/acr_stream_if.sv =====
interface acr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/arp_cache_and_responder_top.sv =====
// Channel   Dir  Payload    Transaction
// req_i     in   acr_in_t   one ARP packet or one resolve query
// rsp_o     out  acr_out_t  one result per accepted item
// cfg       in   we/idx/48b one register write, no handshake
//
// An item is accepted in S_IDLE, whose accept cycle issues the cache write (ARP) or
// the cache read (resolve); S_FIN then loads the output register. An ARP
// reply writes its target entry in S_FIN through the one write port.
// After reset the valid store is swept, one entry a cycle, over all 2**HOST_BITS
// entries (256 by default) with req_i.ready low; register writes are taken.
// A held output stalls only S_FIN; the next item is accepted as soon as
// the result sits in the output register.
module arp_cache_and_responder_top #(
  parameter int unsigned HOST_BITS = acr_pkg::HOST_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [acr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  acr_stream_if.sink                      req_i,
  acr_stream_if.source                    rsp_o
);
  import acr_pkg::*;

  localparam int unsigned ENTRIES = 1 << HOST_BITS;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_FIN   = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [31:0] my_ip_q, mask_q, gateway_q;
  logic [47:0] my_mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_ip_q   <= MY_IP_RST;
      my_mac_q  <= MY_MAC_RST;
      mask_q    <= MASK_RST;
      gateway_q <= GATEWAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MY_IP:   my_ip_q   <= cfg_data_i[31:0];
        CFG_MY_MAC:  my_mac_q  <= cfg_data_i;
        CFG_MASK:    mask_q    <= cfg_data_i[31:0];
        CFG_GATEWAY: gateway_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic accept, load_out, out_free;
  logic out_valid_q;
  acr_out_t rsp_q, rsp_d;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign load_out    = (state_q == S_FIN) && out_free;

  // Next hop and cache keys of the incoming item
  logic [31:0] hop_d, s_host, q_host;
  logic [HOST_BITS-1:0] s_key, q_key;
  logic is_req_d, is_rep_d;

  assign hop_d  = ((req_i.data.query_ip & mask_q) == (mask_q & gateway_q)) ?
                  req_i.data.query_ip : gateway_q;
  assign s_host = req_i.data.sender_ip & ~mask_q;
  assign q_host = hop_d & ~mask_q;
  assign s_key  = s_host[HOST_BITS-1:0];
  assign q_key  = q_host[HOST_BITS-1:0];
  assign is_req_d = (req_i.data.action == ACT_ARP) && (req_i.data.arp_opcode == OP_REQUEST);
  assign is_rep_d = (req_i.data.action == ACT_ARP) && (req_i.data.arp_opcode == OP_REPLY);

  // Item held for the result stage (S_FIN)
  logic        act_q, is_req_q, is_rep_q;
  logic [47:0] s_mac_q, t_mac_q;
  logic [31:0] s_ip_q, t_ip_q, hop_q, t_host;
  logic [HOST_BITS-1:0] t_key;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= req_i.data.action;
      is_req_q <= is_req_d;
      is_rep_q <= is_rep_d;
      s_mac_q  <= req_i.data.sender_mac;
      s_ip_q   <= req_i.data.sender_ip;
      t_mac_q  <= req_i.data.target_mac;
      t_ip_q   <= req_i.data.target_ip;
      hop_q    <= hop_d;
    end
  end

  assign t_host = t_ip_q & ~mask_q;
  assign t_key  = t_host[HOST_BITS-1:0];

  // Clearing sweep counter
  logic [HOST_BITS-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == S_CLEAR) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Cache memories: valid store and MAC store share one write address
  logic                 valid_mem [ENTRIES];
  logic [47:0]          mac_mem   [ENTRIES];
  logic                 vld_we, mac_we, vld_wdata, rd_en;
  logic [HOST_BITS-1:0] w_addr;
  logic [47:0]          mac_wdata;
  logic                 rd_vld_q;
  logic [47:0]          rd_mac_q;

  always_comb begin
    vld_we    = 1'b0;
    mac_we    = 1'b0;
    vld_wdata = 1'b1;
    w_addr    = s_key;
    mac_wdata = req_i.data.sender_mac;
    if (state_q == S_CLEAR) begin
      vld_we    = 1'b1;
      vld_wdata = 1'b0;
      w_addr    = clr_q;
    end else if (accept && (is_req_d || is_rep_d)) begin
      vld_we = 1'b1;
      mac_we = 1'b1;
    end else if ((state_q == S_FIN) && is_rep_q) begin
      // second write of a reply; repeating it while stalled is harmless
      vld_we    = 1'b1;
      mac_we    = 1'b1;
      w_addr    = t_key;
      mac_wdata = t_mac_q;
    end
  end

  assign rd_en = accept && (req_i.data.action == ACT_RESOLVE);

  always_ff @(posedge clk_i) begin
    if (vld_we) begin
      valid_mem[w_addr] <= vld_wdata;
    end
    if (mac_we) begin
      mac_mem[w_addr] <= mac_wdata;
    end
    if (rd_en) begin
      rd_vld_q <= valid_mem[q_key];
      rd_mac_q <= mac_mem[q_key];
    end
  end

  // Result
  always_comb begin
    rsp_d = '0;
    if (act_q == ACT_ARP) begin
      if (is_req_q && (t_ip_q == my_ip_q)) begin
        rsp_d.reply_valid     = 1'b1;
        rsp_d.reply_dest_mac  = s_mac_q;
        rsp_d.reply_target_ip = s_ip_q;
      end
    end else begin
      rsp_d.next_hop_ip = hop_q;
      if (hop_q == my_ip_q) begin
        rsp_d.resolve_hit  = 1'b1;
        rsp_d.resolved_mac = my_mac_q;
      end else if (rd_vld_q) begin
        rsp_d.resolve_hit  = 1'b1;
        rsp_d.resolved_mac = rd_mac_q;
      end else begin
        rsp_d.request_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = rsp_q;

  // Control
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (&clr_q) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !req_i.ready)
    else $error("item accepted during clearing sweep");

  a_accept_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_FIN))
    else $error("accepted item did not reach result stage");

  a_load_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (state_q == S_IDLE) && out_valid_q)
    else $error("result load did not complete the item");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(rsp_q.reply_valid && (rsp_q.resolve_hit || rsp_q.request_valid))
                    && !(rsp_q.resolve_hit && rsp_q.request_valid))
    else $error("result mixes reply, hit and request");

  a_no_write_while_out_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(vld_we && !accept))
    else $error("cache written with no item in progress");

endmodule

// ===== test/tb_arp_cache_and_responder_top.sv =====
module tb_arp_cache_and_responder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import acr_pkg::*;

  localparam int unsigned HOST_BITS   = HOST_BITS_DEF;
  localparam int unsigned ENTRIES     = 1 << HOST_BITS;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  acr_stream_if #(.T(acr_in_t))  req_if ();
  acr_stream_if #(.T(acr_out_t)) rsp_if ();

  arp_cache_and_responder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Predictor state: register copies and the cache
  logic [31:0] my_ip_q;
  logic [47:0] my_mac_q;
  logic [31:0] mask_q;
  logic [31:0] gateway_q;
  bit          cached_valid [ENTRIES];
  logic [47:0] cached_mac   [ENTRIES];

  acr_out_t    pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          sender_idles;
  bit          sink_stalls;

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Sink side: random back-pressure
  always @(negedge clk_i) begin
    rsp_if.ready <= !(sink_stalls && $urandom_range(99) < 29);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [HOST_BITS-1:0] host_key(input logic [31:0] ip);
    logic [31:0] host;
    host = ip & ~mask_q;
    return host[HOST_BITS-1:0];
  endfunction

  function automatic void learn(input logic [31:0] ip, input logic [47:0] mac);
    cached_valid[host_key(ip)] = 1'b1;
    cached_mac[host_key(ip)]   = mac;
  endfunction

  function automatic acr_out_t arp_outcome(input acr_in_t it);
    acr_out_t    res;
    logic [31:0] hop;
    res = '0;
    if (it.action == ACT_ARP) begin
      if (it.arp_opcode == OP_REQUEST) begin
        learn(it.sender_ip, it.sender_mac);
        if (it.target_ip == my_ip_q) begin
          res.reply_valid     = 1'b1;
          res.reply_dest_mac  = it.sender_mac;
          res.reply_target_ip = it.sender_ip;
        end
      end else if (it.arp_opcode == OP_REPLY) begin
        // sender first, so the target wins on a shared key
        learn(it.sender_ip, it.sender_mac);
        learn(it.target_ip, it.target_mac);
      end
    end else begin
      hop = ((it.query_ip & mask_q) == (gateway_q & mask_q)) ? it.query_ip : gateway_q;
      res.next_hop_ip = hop;
      if (hop == my_ip_q) begin
        res.resolve_hit  = 1'b1;
        res.resolved_mac = my_mac_q;
      end else if (cached_valid[host_key(hop)]) begin
        res.resolve_hit  = 1'b1;
        res.resolved_mac = cached_mac[host_key(hop)];
      end else begin
        res.request_valid = 1'b1;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("%0t ns: %s got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    acr_out_t got;
    acr_out_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.reply_valid !== want.reply_valid)
          report_mismatch("reply_valid", 48'(got.reply_valid), 48'(want.reply_valid));
        if (got.reply_dest_mac !== want.reply_dest_mac)
          report_mismatch("reply_dest_mac", got.reply_dest_mac, want.reply_dest_mac);
        if (got.reply_target_ip !== want.reply_target_ip)
          report_mismatch("reply_target_ip", 48'(got.reply_target_ip),
                          48'(want.reply_target_ip));
        if (got.resolve_hit !== want.resolve_hit)
          report_mismatch("resolve_hit", 48'(got.resolve_hit), 48'(want.resolve_hit));
        if (got.resolved_mac !== want.resolved_mac)
          report_mismatch("resolved_mac", got.resolved_mac, want.resolved_mac);
        if (got.request_valid !== want.request_valid)
          report_mismatch("request_valid", 48'(got.request_valid),
                          48'(want.request_valid));
        if (got.next_hop_ip !== want.next_hop_ip)
          report_mismatch("next_hop_ip", 48'(got.next_hop_ip), 48'(want.next_hop_ip));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after the transaction.
  // Valid is left high so back-to-back items need no second assignment.
  task automatic send_item(input acr_in_t it);
    while (sender_idles && $urandom_range(99) < 29) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(arp_outcome(it));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_MY_IP:   my_ip_q   = value[31:0];
      CFG_MY_MAC:  my_mac_q  = value[47:0];
      CFG_MASK:    mask_q    = value[31:0];
      CFG_GATEWAY: gateway_q = value[31:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] ip, input logic [47:0] mac,
                            input logic [31:0] mask, input logic [31:0] gw);
    wait_drained();
    put_reg(CFG_MY_IP, CFG_DATA_W'(ip));
    put_reg(CFG_MY_MAC, mac);
    put_reg(CFG_MASK, CFG_DATA_W'(mask));
    put_reg(CFG_GATEWAY, CFG_DATA_W'(gw));
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Address on the current subnet, mostly from a small pool of hosts so
  // that lookups find what earlier packets stored
  function automatic logic [31:0] local_ip();
    logic [31:0] host;
    host = ($urandom_range(99) < 20) ? 32'($urandom) : 32'($urandom_range(23));
    return (gateway_q & mask_q) | (host & ~mask_q);
  endfunction

  function automatic acr_in_t arp_item(input logic [15:0] op,
                                       input logic [47:0] s_mac, input logic [31:0] s_ip,
                                       input logic [47:0] t_mac, input logic [31:0] t_ip);
    acr_in_t it;
    it.action     = ACT_ARP;
    it.arp_opcode = op;
    it.sender_mac = s_mac;
    it.sender_ip  = s_ip;
    it.target_mac = t_mac;
    it.target_ip  = t_ip;
    it.query_ip   = $urandom;
    return it;
  endfunction

  function automatic acr_in_t resolve_item(input logic [31:0] q_ip);
    acr_in_t it;
    it = arp_item(16'($urandom), rand_mac(), $urandom, rand_mac(), $urandom);
    it.action   = ACT_RESOLVE;
    it.query_ip = q_ip;
    return it;
  endfunction

  function automatic acr_in_t random_item();
    acr_in_t     it;
    int unsigned pick;
    int unsigned r;
    pick = $urandom_range(99);
    it = arp_item(OP_REQUEST, rand_mac(), local_ip(), rand_mac(), local_ip());
    if (pick < 10) begin
      // noise: anything at all
      it.action     = 1'($urandom);
      it.arp_opcode = 16'($urandom);
      it.sender_ip  = $urandom;
      it.target_ip  = $urandom;
    end else if (pick < 40) begin
      if ($urandom_range(99) < 35) it.target_ip = my_ip_q;
    end else if (pick < 55) begin
      it.arp_opcode = OP_REPLY;
      if ($urandom_range(99) < 15) it.sender_ip = gateway_q;
      if ($urandom_range(99) < 20) it.target_ip = it.sender_ip;
    end else begin
      r = $urandom_range(99);
      if (r < 15)      it = resolve_item(my_ip_q);
      else if (r < 25) it = resolve_item(gateway_q);
      else if (r < 45) it = resolve_item($urandom);
      else             it = resolve_item(local_ip());
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings: own address, replies, shared keys, gateway, unknown opcodes
  task automatic test_default_settings();
    send_item(resolve_item(MY_IP_RST));
    send_item(resolve_item(32'hC0A8_0105));
    send_item(arp_item(OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'hC0A8_0105, '0, MY_IP_RST));
    send_item(resolve_item(32'hC0A8_0105));
    send_item(arp_item(OP_REQUEST, 48'h0, 32'hC0A8_0107, 48'hFFFF_FFFF_FFFF,
                       32'hC0A8_0199));
    send_item(resolve_item(32'hC0A8_0107));
    // reply whose sender and target share a key
    send_item(arp_item(OP_REPLY, 48'h1111_1111_1111, 32'hC0A8_0110, 48'h2222_2222_2222,
                       32'hC0A8_0210));
    send_item(resolve_item(32'hC0A8_0110));
    send_item(resolve_item(32'h0808_0808));
    send_item(arp_item(OP_REPLY, 48'hA5A5_5A5A_0F0F, GATEWAY_RST, 48'h5A5A_A5A5_F0F0,
                       32'hC0A8_0120));
    send_item(resolve_item(32'h0808_0808));
    // unknown opcodes leave the cache alone
    send_item(arp_item(16'h0000, rand_mac(), 32'hC0A8_0130, rand_mac(), MY_IP_RST));
    send_item(arp_item(16'hFFFF, rand_mac(), 32'hC0A8_0130, rand_mac(), MY_IP_RST));
    send_item(arp_item(16'h0101, rand_mac(), 32'hC0A8_0130, rand_mac(), 32'hC0A8_0131));
    send_item(resolve_item(32'hC0A8_0130));
    send_item(resolve_item(32'hFFFF_FFFF));
    send_item(resolve_item(32'h0000_0000));
    send_item(arp_item(OP_REQUEST, rand_mac(), 32'hFFFF_FFFF, rand_mac(), 32'hFFFF_FFFF));
    send_item(resolve_item(32'hC0A8_01FF));
  endtask

  // Register extremes: empty mask aliases wide hosts, full mask folds to one key
  task automatic test_register_extremes();
    set_config(32'h0, 48'hFFFF_FFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_item(resolve_item(32'h0));
    send_item(arp_item(OP_REQUEST, 48'h0123_4567_89AB, 32'h0000_0105, rand_mac(), 32'h0));
    send_item(resolve_item(32'hABCD_0005));
    set_config(32'hFFFF_FFFF, 48'h0123_4567_89AB, 32'hFFFF_FFFF, 32'h0);
    send_item(resolve_item(32'h0));
    send_item(arp_item(OP_REPLY, 48'hFEDC_BA98_7654, 32'h1234_5678, 48'h0000_0000_0001,
                       32'h8765_4321));
    send_item(resolve_item(32'h5555_5555));
  endtask

  // Random traffic across several settings
  task automatic test_random_traffic();
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] mask;
    logic [31:0] gw;
    int unsigned counted;
    acr_in_t     it;
    for (int phase = 0; phase < 6; phase++) begin
      sender_idles = 1'b1;
      sink_stalls  = 1'b1;
      gw   = $urandom;
      mac  = rand_mac();
      mask = MASK_RST;
      case (phase)
        0: begin
          gw   = GATEWAY_RST;
          mac  = MY_MAC_RST;
        end
        1: begin
          // long stretch without idling on either side
          sender_idles = 1'b0;
          sink_stalls  = 1'b0;
        end
        2: begin
          mask = 32'h0;
          mac  = 48'hFFFF_FFFF_FFFF;
        end
        3: begin
          mask = 32'hFFFF_FFFF;
          mac  = 48'h0;
        end
        4: mask = 32'hFFFF_FFFF << (32 - $urandom_range(16, 30));
        default: mask = 32'hFFFF_FFFF << (32 - $urandom_range(16, 22));
      endcase
      ip = (gw & mask) | (32'($urandom_range(23)) & ~mask);
      if (phase == 0) ip = MY_IP_RST;
      if (phase == 3) ip = $urandom;
      set_config(ip, mac, mask, gw);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = random_item();
        send_item(it);
        if (it.action == ACT_RESOLVE || it.arp_opcode == OP_REQUEST ||
            it.arp_opcode == OP_REPLY)
          counted++;
        // hold the sender until the pipeline has emptied
        if (counted == PHASE_ITEMS / 2) wait_drained();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MY_IP;
    cfg_data_i    = '0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    rsp_if.ready  = 1'b0;
    sender_idles  = 1'b1;
    sink_stalls   = 1'b1;
    my_ip_q       = MY_IP_RST;
    my_mac_q      = MY_MAC_RST;
    mask_q        = MASK_RST;
    gateway_q     = GATEWAY_RST;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_settings();
    test_register_extremes();
    test_random_traffic();

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
